@@ hw/rtl/tipl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tipl_pkg
// Shared types and constants of the tip/inner partial-likelihood unit.
// ----------------------------------------------------------------------------
package tipl_pkg;

  localparam int MAX_STATES = 16;
  localparam int MAX_RATES  = 4;
  localparam int STATE_W    = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int RATE_W     = (MAX_RATES > 1) ? $clog2(MAX_RATES) : 1;
  localparam int MAT_AW     = RATE_W + 2 * STATE_W;
  localparam int VEC_AW     = RATE_W + STATE_W;
  localparam int MAT_DEPTH  = MAX_RATES * MAX_STATES * MAX_STATES;
  localparam int VEC_DEPTH  = MAX_RATES * MAX_STATES;
  localparam int CODE_DEPTH = 256;

  // input commands
  localparam logic [1:0] CMD_TIP_MAT   = 2'd0;
  localparam logic [1:0] CMD_INNER_MAT = 2'd1;
  localparam logic [1:0] CMD_CODE_MASK = 2'd2;
  localparam logic [1:0] CMD_SITE      = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_STATE_COUNT = 3'd0;
  localparam logic [2:0] CFG_RATE_COUNT  = 3'd1;
  localparam logic [2:0] CFG_SCALE_EN    = 3'd2;
  localparam logic [2:0] CFG_SCALE_THR   = 3'd3;
  localparam logic [2:0] CFG_SCALE_FAC   = 3'd4;

  localparam logic [63:0] RST_SCALE_THR = 64'h2FF0_0000_0000_0000;
  localparam logic [63:0] RST_SCALE_FAC = 64'h4FF0_0000_0000_0000;

  // double constants
  localparam logic [63:0] DBL_DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
  localparam logic [63:0] DBL_QUIET_BIT   = 64'h0008_0000_0000_0000;
  localparam logic [63:0] DBL_POS_ZERO    = 64'h0;

  typedef struct packed {
    logic [1:0]  command;
    logic [1:0]  rate_index;
    logic [3:0]  row_index;
    logic [3:0]  col_index;
    logic [63:0] value;
    logic [7:0]  tip_code;
    logic [15:0] inner_scale;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  out_rate;
    logic [3:0]  out_state;
    logic [63:0] out_value;
    logic [15:0] scale_count;
    logic        last;
  } out_item_t;

  typedef enum logic [0:0] {
    FOP_ADD,
    FOP_MUL
  } fpu_op_t;

  typedef struct packed {
    logic    start;
    fpu_op_t op;
  } fpu_req_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_PREP,
    F_MUL,
    F_NORM,
    F_DENORM,
    F_ROUND,
    F_DONE
  } fpu_state_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MASK,
    ST_FETCH,
    ST_TADD,
    ST_MUL,
    ST_TBADD,
    ST_PROD,
    ST_ORD,
    ST_OLOAD,
    ST_OSCALE,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

@@ hw/rtl/tipl_fpu.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tipl_fpu
// Multi-cycle IEEE double add/multiply unit, round to nearest even.
// ----------------------------------------------------------------------------
module tipl_fpu (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tipl_pkg::fpu_req_t req,
  input  wire logic [63:0]       a,
  input  wire logic [63:0]       b,
  output logic                   done,
  output logic [63:0]            y
);

  tipl_pkg::fpu_state_t state, state_next;
  tipl_pkg::fpu_op_t    op;
  logic [63:0]          a_r, b_r;
  logic [127:0]         man;
  logic signed [13:0]   xe;
  logic                 sign;
  logic [2:0]           mcnt;
  logic [53:0]          pp;
  logic [6:0]           pp_sh;
  logic [13:0]          dcnt;
  logic [10:0]          e_fin;

  // operand fields
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [52:0] ma, mb;
  logic [10:0] ea, eb;

  always_comb begin
    a_nan  = (a_r[62:52] == 11'h7FF) && (a_r[51:0] != 52'd0);
    b_nan  = (b_r[62:52] == 11'h7FF) && (b_r[51:0] != 52'd0);
    a_inf  = (a_r[62:52] == 11'h7FF) && (a_r[51:0] == 52'd0);
    b_inf  = (b_r[62:52] == 11'h7FF) && (b_r[51:0] == 52'd0);
    a_zero = (a_r[62:0] == 63'd0);
    b_zero = (b_r[62:0] == 63'd0);
    ma     = {a_r[62:52] != 11'd0, a_r[51:0]};
    mb     = {b_r[62:52] != 11'd0, b_r[51:0]};
    ea     = (a_r[62:52] == 11'd0) ? 11'd1 : a_r[62:52];
    eb     = (b_r[62:52] == 11'd0) ? 11'd1 : b_r[62:52];
  end

  // add alignment and sum
  logic        swap, s_big, s_sml;
  logic [52:0] m_big, m_sml;
  logic [10:0] e_big, d;
  logic [55:0] al_a, al_b;
  logic [111:0] wide;
  logic [56:0] sum;
  logic        sum_sign;

  always_comb begin
    swap  = eb > ea;
    m_big = swap ? mb : ma;
    m_sml = swap ? ma : mb;
    e_big = swap ? eb : ea;
    s_big = swap ? b_r[63] : a_r[63];
    s_sml = swap ? a_r[63] : b_r[63];
    d     = e_big - (swap ? ea : eb);
    al_a  = {m_big, 3'b000};
    wide  = {m_sml, 3'b000, 56'd0} >> d[5:0];
    if (d >= 11'd56) begin
      al_b = {55'd0, |m_sml};
    end else begin
      al_b = {wide[111:57], wide[56] | (|wide[55:0])};
    end
    if (s_big == s_sml) begin
      sum      = {1'b0, al_a} + {1'b0, al_b};
      sum_sign = s_big;
    end else if (al_a >= al_b) begin
      sum      = {1'b0, al_a} - {1'b0, al_b};
      sum_sign = s_big;
    end else begin
      sum      = {1'b0, al_b} - {1'b0, al_a};
      sum_sign = s_sml;
    end
  end

  // partial product operand select: 27-bit slices
  logic [26:0] pa, pb;
  always_comb begin
    pa = mcnt[1] ? {1'b0, ma[52:27]} : ma[26:0];
    pb = mcnt[0] ? {1'b0, mb[52:27]} : mb[26:0];
  end

  // normalize / round helpers
  logic signed [13:0] e_calc;
  logic [52:0]        q;
  logic               rnd_inc;
  logic [53:0]        q_rnd;
  logic [62:0]        body;

  always_comb begin
    e_calc  = xe + 14'sd1150;
    q       = man[127:75];
    rnd_inc = man[74] & ((|man[73:0]) | q[0]);
    q_rnd   = {1'b0, q} + {53'd0, rnd_inc};
    body    = {e_fin - 11'd1, 52'd0} + {9'd0, q_rnd};
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tipl_pkg::F_IDLE:   if (req.start) state_next = tipl_pkg::F_PREP;
      tipl_pkg::F_PREP: begin
        if (a_nan || b_nan || a_inf || b_inf) begin
          state_next = tipl_pkg::F_DONE;
        end else if (op == tipl_pkg::FOP_MUL) begin
          state_next = tipl_pkg::F_MUL;
        end else begin
          state_next = tipl_pkg::F_NORM;
        end
      end
      tipl_pkg::F_MUL:    if (mcnt == 3'd4) state_next = tipl_pkg::F_NORM;
      tipl_pkg::F_NORM: begin
        if (man == 128'd0) begin
          state_next = tipl_pkg::F_DONE;
        end else if (man[127]) begin
          if (e_calc >= 14'sd2047) state_next = tipl_pkg::F_DONE;
          else if (e_calc <= 14'sd0) state_next = tipl_pkg::F_DENORM;
          else state_next = tipl_pkg::F_ROUND;
        end
      end
      tipl_pkg::F_DENORM: begin
        if (dcnt > 14'd127 || dcnt == 14'd0) state_next = tipl_pkg::F_ROUND;
      end
      tipl_pkg::F_ROUND:  state_next = tipl_pkg::F_DONE;
      tipl_pkg::F_DONE:   state_next = tipl_pkg::F_IDLE;
      default:            state_next = tipl_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    done = (state == tipl_pkg::F_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tipl_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      tipl_pkg::F_IDLE: begin
        if (req.start) begin
          a_r <= a;
          b_r <= b;
          op  <= req.op;
        end
      end
      tipl_pkg::F_PREP: begin
        mcnt <= 3'd0;
        if (a_nan) begin
          y <= a_r | tipl_pkg::DBL_QUIET_BIT;
        end else if (b_nan) begin
          y <= b_r | tipl_pkg::DBL_QUIET_BIT;
        end else if (op == tipl_pkg::FOP_MUL) begin
          if ((a_inf && b_zero) || (a_zero && b_inf)) begin
            y <= tipl_pkg::DBL_DEFAULT_NAN;
          end else begin
            y <= {a_r[63] ^ b_r[63], 11'h7FF, 52'd0};
          end
          sign <= a_r[63] ^ b_r[63];
          man  <= 128'd0;
          xe   <= $signed({3'b000, ea}) + $signed({3'b000, eb}) - 14'sd2150;
        end else begin
          if (a_inf && b_inf && (a_r[63] != b_r[63])) begin
            y <= tipl_pkg::DBL_DEFAULT_NAN;
          end else if (a_inf) begin
            y <= a_r;
          end else begin
            y <= b_r;
          end
          // exact zero of a sum is negative only when both addends are
          sign <= (sum == 57'd0) ? (a_r[63] & b_r[63]) : sum_sign;
          man  <= {71'd0, sum};
          xe   <= $signed({3'b000, e_big}) - 14'sd1078;
        end
      end
      tipl_pkg::F_MUL: begin
        if (mcnt != 3'd4) begin
          pp    <= 54'(pa * pb);
          pp_sh <= 7'((mcnt[1] ? 27 : 0) + (mcnt[0] ? 27 : 0));
        end
        if (mcnt != 3'd0) begin
          man <= man + ({74'd0, pp} << pp_sh);
        end
        mcnt <= mcnt + 3'd1;
      end
      tipl_pkg::F_NORM: begin
        if (man == 128'd0) begin
          y <= {sign, 63'd0};
        end else if (man[127]) begin
          if (e_calc >= 14'sd2047) begin
            y <= {sign, 11'h7FF, 52'd0};
          end else if (e_calc <= 14'sd0) begin
            dcnt  <= 14'(14'sd1 - e_calc);
            e_fin <= 11'd1;
          end else begin
            e_fin <= e_calc[10:0];
          end
        end else if (man[127:96] == 32'd0) begin
          man <= man << 32;
          xe  <= xe - 14'sd32;
        end else if (man[127:120] == 8'd0) begin
          man <= man << 8;
          xe  <= xe - 14'sd8;
        end else begin
          man <= man << 1;
          xe  <= xe - 14'sd1;
        end
      end
      tipl_pkg::F_DENORM: begin
        // shift right, folding lost bits into the sticky bit
        if (dcnt > 14'd127) begin
          man  <= {127'd0, |man};
          dcnt <= 14'd0;
        end else if (dcnt >= 14'd32) begin
          man  <= {32'd0, man[127:33], man[32] | (|man[31:0])};
          dcnt <= dcnt - 14'd32;
        end else if (dcnt >= 14'd8) begin
          man  <= {8'd0, man[127:9], man[8] | (|man[7:0])};
          dcnt <= dcnt - 14'd8;
        end else if (dcnt != 14'd0) begin
          man  <= {1'b0, man[127:2], man[1] | man[0]};
          dcnt <= dcnt - 14'd1;
        end
      end
      tipl_pkg::F_ROUND: begin
        y <= {sign, body};
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/tip_inner_partial_likelihood.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tip_inner_partial_likelihood
// One site of a parent likelihood vector from a tip child and an inner child.
// ----------------------------------------------------------------------------
//  channel | signals                           | direction
//  --------+-----------------------------------+-----------
//  input   | in_valid, in_stall, in_data       | items in
//  output  | out_valid, out_stall, out_data    | results out
//  config  | cfg_write, cfg_index, cfg_data    | register writes
//
// Table loads and non-final site elements are taken whenever the unit is idle.
// The final site element starts a run over R rates and S states: for each
// parent state and child state it runs a tip add (only where the tip mask
// bit is set), an inner multiply and an inner add; each row ends in a multiply
// of the two sums. Results are then emitted, each scaled by a multiply while
// scaling stays on; all arithmetic goes through the one shared double unit.
// No item is taken during the run. Reset clears control state only; the
// tables are undefined until loaded. A stalled result holds the run.
// ----------------------------------------------------------------------------
module tip_inner_partial_likelihood (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire tipl_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output tipl_pkg::out_item_t      out_data,
  input  wire logic                cfg_write,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [63:0]         cfg_data
);

  // configuration registers
  logic [4:0]  state_count;
  logic [2:0]  rate_count;
  logic        scaling_enable;
  logic [63:0] scale_threshold;
  logic [63:0] scale_factor;

  always_ff @(posedge clk) begin
    if (rst) begin
      state_count     <= 5'd16;
      rate_count      <= 3'd4;
      scaling_enable  <= 1'b0;
      scale_threshold <= tipl_pkg::RST_SCALE_THR;
      scale_factor    <= tipl_pkg::RST_SCALE_FAC;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tipl_pkg::CFG_STATE_COUNT: state_count     <= cfg_data[4:0];
        tipl_pkg::CFG_RATE_COUNT:  rate_count      <= cfg_data[2:0];
        tipl_pkg::CFG_SCALE_EN:    scaling_enable  <= cfg_data[0];
        tipl_pkg::CFG_SCALE_THR:   scale_threshold <= cfg_data;
        tipl_pkg::CFG_SCALE_FAC:   scale_factor    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // clamp counts: zero acts as one, above the maximum saturates
  logic [tipl_pkg::STATE_W-1:0] ns_m1;
  logic [tipl_pkg::RATE_W-1:0]  nr_m1;

  always_comb begin
    if (state_count == 5'd0) begin
      ns_m1 = '0;
    end else if (32'(state_count) > tipl_pkg::MAX_STATES) begin
      ns_m1 = tipl_pkg::STATE_W'(tipl_pkg::MAX_STATES - 1);
    end else begin
      ns_m1 = tipl_pkg::STATE_W'(state_count - 5'd1);
    end
    if (rate_count == 3'd0) begin
      nr_m1 = '0;
    end else if (32'(rate_count) > tipl_pkg::MAX_RATES) begin
      nr_m1 = tipl_pkg::RATE_W'(tipl_pkg::MAX_RATES - 1);
    end else begin
      nr_m1 = tipl_pkg::RATE_W'(rate_count - 3'd1);
    end
  end

  tipl_pkg::state_t state, state_next;

  logic [tipl_pkg::RATE_W-1:0]  r;
  logic [tipl_pkg::STATE_W-1:0] i, j;
  logic [7:0]   site_code;
  logic [15:0]  site_scale;
  logic         scale;
  logic         launched;
  logic [63:0]  ta, tb, tmp;

  // input decode
  logic in_xfer, mat_ok, vec_ok, site_trig;
  always_comb begin
    in_xfer   = in_valid && !in_stall;
    mat_ok    = (32'(in_data.rate_index) < tipl_pkg::MAX_RATES) &&
                (32'(in_data.row_index) < tipl_pkg::MAX_STATES) &&
                (32'(in_data.col_index) < tipl_pkg::MAX_STATES);
    vec_ok    = (32'(in_data.rate_index) < tipl_pkg::MAX_RATES) &&
                (32'(in_data.col_index) < tipl_pkg::MAX_STATES);
    site_trig = (in_data.command == tipl_pkg::CMD_SITE) &&
                (32'(in_data.rate_index) == 32'(nr_m1)) &&
                (32'(in_data.col_index) == 32'(ns_m1));
  end

  logic [tipl_pkg::MAT_AW-1:0] wr_mat_addr, rd_mat_addr;
  logic [tipl_pkg::VEC_AW-1:0] wr_vec_addr, rd_vec_addr, prod_addr;
  always_comb begin
    wr_mat_addr = {in_data.rate_index[tipl_pkg::RATE_W-1:0],
                   in_data.row_index[tipl_pkg::STATE_W-1:0],
                   in_data.col_index[tipl_pkg::STATE_W-1:0]};
    wr_vec_addr = {in_data.rate_index[tipl_pkg::RATE_W-1:0],
                   in_data.col_index[tipl_pkg::STATE_W-1:0]};
    rd_mat_addr = {r, i, j};
    rd_vec_addr = {r, j};
    prod_addr   = {r, i};
  end

  // memories, registered reads
  logic [63:0] tip_mem   [tipl_pkg::MAT_DEPTH];
  logic [63:0] inner_mem [tipl_pkg::MAT_DEPTH];
  logic [15:0] mask_mem  [tipl_pkg::CODE_DEPTH];
  logic [63:0] site_mem  [tipl_pkg::VEC_DEPTH];
  logic [63:0] prod_mem  [tipl_pkg::VEC_DEPTH];
  logic [63:0] tip_q, inner_q, site_q, prod_q;
  logic [15:0] mask_q;

  // shared double unit
  tipl_pkg::fpu_req_t fpu_req;
  logic [63:0]        fpu_a, fpu_b, fpu_y;
  logic               fpu_done;

  tipl_fpu u_fpu (
    .clk  (clk),
    .rst  (rst),
    .req  (fpu_req),
    .a    (fpu_a),
    .b    (fpu_b),
    .done (fpu_done),
    .y    (fpu_y)
  );

  logic mask_bit;
  logic prod_lt;
  logic [15:0] cnt_out;
  logic last_elem;

  // a < b on doubles; NaN compares false, signed zeros are equal
  function automatic logic dbl_lt(input logic [63:0] x, input logic [63:0] t);
    logic x_nan, t_nan;
    x_nan = (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
    t_nan = (t[62:52] == 11'h7FF) && (t[51:0] != 52'd0);
    if (x_nan || t_nan) return 1'b0;
    if (x[62:0] == 63'd0 && t[62:0] == 63'd0) return 1'b0;
    if (x[63] != t[63]) return x[63];
    if (!x[63]) return x[62:0] < t[62:0];
    return x[62:0] > t[62:0];
  endfunction

  always_comb begin
    mask_bit  = mask_q[j];
    prod_lt   = dbl_lt(fpu_y, scale_threshold);
    last_elem = (r == nr_m1) && (i == ns_m1);
    if (scale && site_scale != 16'hFFFF) cnt_out = site_scale + 16'd1;
    else cnt_out = site_scale;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tipl_pkg::ST_IDLE:   if (in_xfer && site_trig) state_next = tipl_pkg::ST_MASK;
      tipl_pkg::ST_MASK:   state_next = tipl_pkg::ST_FETCH;
      tipl_pkg::ST_FETCH:  state_next = tipl_pkg::ST_TADD;
      tipl_pkg::ST_TADD:   if (!mask_bit || fpu_done) state_next = tipl_pkg::ST_MUL;
      tipl_pkg::ST_MUL:    if (fpu_done) state_next = tipl_pkg::ST_TBADD;
      tipl_pkg::ST_TBADD: begin
        if (fpu_done) begin
          state_next = (j == ns_m1) ? tipl_pkg::ST_PROD : tipl_pkg::ST_FETCH;
        end
      end
      tipl_pkg::ST_PROD: begin
        if (fpu_done) begin
          state_next = last_elem ? tipl_pkg::ST_ORD : tipl_pkg::ST_FETCH;
        end
      end
      tipl_pkg::ST_ORD:    state_next = tipl_pkg::ST_OLOAD;
      tipl_pkg::ST_OLOAD:  state_next = scale ? tipl_pkg::ST_OSCALE : tipl_pkg::ST_OUT;
      tipl_pkg::ST_OSCALE: if (fpu_done) state_next = tipl_pkg::ST_OUT;
      tipl_pkg::ST_OUT: begin
        if (!out_stall) begin
          state_next = last_elem ? tipl_pkg::ST_IDLE : tipl_pkg::ST_ORD;
        end
      end
      default:             state_next = tipl_pkg::ST_IDLE;
    endcase
  end

  // outputs and unit requests
  always_comb begin
    in_stall    = (state != tipl_pkg::ST_IDLE);
    out_valid   = (state == tipl_pkg::ST_OUT);
    fpu_req.op  = tipl_pkg::FOP_ADD;
    fpu_a       = ta;
    fpu_b       = tip_q;
    unique case (state)
      tipl_pkg::ST_MUL: begin
        fpu_req.op = tipl_pkg::FOP_MUL;
        fpu_a      = inner_q;
        fpu_b      = site_q;
      end
      tipl_pkg::ST_TBADD: begin
        fpu_a = tb;
        fpu_b = tmp;
      end
      tipl_pkg::ST_PROD: begin
        fpu_req.op = tipl_pkg::FOP_MUL;
        fpu_a      = ta;
        fpu_b      = tb;
      end
      tipl_pkg::ST_OSCALE: begin
        fpu_req.op = tipl_pkg::FOP_MUL;
        fpu_a      = prod_q;
        fpu_b      = scale_factor;
      end
      default: begin
      end
    endcase
    fpu_req.start = !launched &&
                    ((state == tipl_pkg::ST_TADD && mask_bit) ||
                     state == tipl_pkg::ST_MUL || state == tipl_pkg::ST_TBADD ||
                     state == tipl_pkg::ST_PROD || state == tipl_pkg::ST_OSCALE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= tipl_pkg::ST_IDLE;
      launched <= 1'b0;
    end else begin
      state <= state_next;
      if (fpu_done) launched <= 1'b0;
      else if (fpu_req.start) launched <= 1'b1;
    end
  end

  // memories: tables write on load transfers, products on each row result; all read every cycle
  always_ff @(posedge clk) begin
    if (in_xfer && in_data.command == tipl_pkg::CMD_TIP_MAT && mat_ok) begin
      tip_mem[wr_mat_addr] <= in_data.value;
    end
    tip_q <= tip_mem[rd_mat_addr];
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_data.command == tipl_pkg::CMD_INNER_MAT && mat_ok) begin
      inner_mem[wr_mat_addr] <= in_data.value;
    end
    inner_q <= inner_mem[rd_mat_addr];
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_data.command == tipl_pkg::CMD_CODE_MASK) begin
      mask_mem[in_data.tip_code] <= in_data.value[15:0];
    end
    mask_q <= mask_mem[site_code];
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_data.command == tipl_pkg::CMD_SITE && vec_ok) begin
      site_mem[wr_vec_addr] <= in_data.value;
    end
    site_q <= site_mem[rd_vec_addr];
  end

  always_ff @(posedge clk) begin
    if (state == tipl_pkg::ST_PROD && fpu_done) begin
      prod_mem[prod_addr] <= fpu_y;
    end
    prod_q <= prod_mem[prod_addr];
  end

  // site latches and sequencing counters
  always_ff @(posedge clk) begin
    if (rst) begin
      site_code  <= 8'd0;
      site_scale <= 16'd0;
    end else if (in_xfer && in_data.command == tipl_pkg::CMD_SITE) begin
      site_code  <= in_data.tip_code;
      site_scale <= in_data.inner_scale;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      tipl_pkg::ST_IDLE: begin
        r     <= '0;
        i     <= '0;
        j     <= '0;
        ta    <= tipl_pkg::DBL_POS_ZERO;
        tb    <= tipl_pkg::DBL_POS_ZERO;
        scale <= scaling_enable;
      end
      tipl_pkg::ST_TADD:  if (fpu_done) ta <= fpu_y;
      tipl_pkg::ST_MUL:   if (fpu_done) tmp <= fpu_y;
      tipl_pkg::ST_TBADD: begin
        if (fpu_done) begin
          tb <= fpu_y;
          if (j != ns_m1) j <= j + 1'b1;
        end
      end
      tipl_pkg::ST_PROD: begin
        if (fpu_done) begin
          scale <= scale && prod_lt;
          ta    <= tipl_pkg::DBL_POS_ZERO;
          tb    <= tipl_pkg::DBL_POS_ZERO;
          j     <= '0;
          // advance to the next row; after the last, restart for emission
          if (i == ns_m1) begin
            i <= '0;
            r <= (r == nr_m1) ? '0 : r + 1'b1;
          end else begin
            i <= i + 1'b1;
          end
        end
      end
      tipl_pkg::ST_OLOAD: begin
        if (!scale) begin
          out_data <= '{out_rate: 2'(r), out_state: 4'(i), out_value: prod_q,
                        scale_count: cnt_out, last: last_elem};
        end
      end
      tipl_pkg::ST_OSCALE: begin
        if (fpu_done) begin
          out_data <= '{out_rate: 2'(r), out_state: 4'(i), out_value: fpu_y,
                        scale_count: cnt_out, last: last_elem};
        end
      end
      tipl_pkg::ST_OUT: begin
        if (!out_stall && !last_elem) begin
          if (i == ns_m1) begin
            i <= '0;
            r <= r + 1'b1;
          end else begin
            i <= i + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // checks
  a_done_launched: assert property (@(posedge clk) disable iff (rst)
    fpu_done |-> launched)
    else $error("double unit finished without a request");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && out_data.last) |=> state == tipl_pkg::ST_IDLE)
    else $error("site did not end after its last result");

  a_trig_run: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && site_trig) |=> state == tipl_pkg::ST_MASK)
    else $error("final site element did not start a run");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_xfer && out_valid))
    else $error("input taken while a result is pending");

endmodule
`default_nettype wire
